// ===== design/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// cts_pkg: shared definitions for the calorimeter tower selector
// Field widths, command, register and verdict codes, and the control and
// status bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int TOWER_W     = 13;
  localparam int ENERGY_W    = 16;
  localparam int ETA_W       = 15;
  localparam int LEVEL_W     = 15;
  localparam int COSH_W      = 16;
  localparam int VERDICT_W   = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 15;

  // Eta is Q3.12 and the cosh table steps in 1/256, so drop four bits.
  localparam int ETA_SHIFT   = 4;
  // Cosh entries are Q6.10.
  localparam int Q10_SHIFT   = 10;

  localparam logic CMD_SELECT = 1'b0;
  localparam logic CMD_MARK   = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_ET_MIN_ENABLE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ET_MAX_ENABLE      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ET_MIN_LEVEL       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ET_MAX_LEVEL       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KILL_EVENT_ON_HIGH = 3'd4;

  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT       = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_REJECT_TOWER = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_REJECT_EVENT = 2'd2;

  typedef struct packed {
    logic clear_step;  // write one zero of the reset sweep
    logic capture;     // select item transfer: lookups start
    logic mark;        // mark item transfer: set the bad bit
    logic mult;        // form the threshold products
    logic load_out;    // load the verdict into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_mark;     // item offered on the input is a mark command
    logic clear_last;  // sweep is at the last tower
    logic out_free;    // output register can take a verdict this cycle
  } ctrl_status_t;

endpackage

// ===== design/cts_ctrl.sv =====
// ----------------------------------------------------------------------------
// cts_ctrl: sequencing state machine
// Runs the reset sweep of the bad map, then steps each select item through
// lookup, multiply and compare while mark items complete on transfer.
// ----------------------------------------------------------------------------
module cts_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cts_pkg::ctrl_status_t status,
  output cts_pkg::ctrl_cmd_t    cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_MULT  = 2'd2;
  localparam logic [1:0] S_CMP   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.clear_step = (state == S_CLEAR);
    cmd.capture    = (state == S_IDLE) && in_valid && !status.is_mark;
    cmd.mark       = (state == S_IDLE) && in_valid && status.is_mark;
    cmd.mult       = (state == S_MULT);
    cmd.load_out   = (state == S_CMP) && status.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.capture) state_next = S_MULT;
      end
      S_MULT: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/cts_datapath.sv =====
// ----------------------------------------------------------------------------
// cts_datapath: bad map, cosh table, threshold multipliers and verdict
// Holds the configuration registers, the one-bit bad map memory with its
// reset sweep counter, the registered cosh lookup and the output register.
// ----------------------------------------------------------------------------
module cts_datapath #(
  parameter int NUM_TOWERS         = 8192,
  parameter int COSH_TABLE_ENTRIES = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  command,
  input  logic        [cts_pkg::TOWER_W-1:0]    tower_number,
  input  logic signed [cts_pkg::ENERGY_W-1:0]   tower_energy,
  input  logic signed [cts_pkg::ETA_W-1:0]      pseudorapidity,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic        [cts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic        [cts_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic        [cts_pkg::VERDICT_W-1:0]  verdict,
  input  cts_pkg::ctrl_cmd_t                    cmd,
  output cts_pkg::ctrl_status_t                 status
);

  localparam int AW   = $clog2(NUM_TOWERS);
  localparam int IW   = $clog2(COSH_TABLE_ENTRIES);
  localparam int TXW  = ((AW > cts_pkg::TOWER_W) ? AW : cts_pkg::TOWER_W) + 1;
  localparam int IRW  = cts_pkg::ETA_W - cts_pkg::ETA_SHIFT;
  localparam int IXW  = ((IRW > IW) ? IRW : IW) + 1;
  localparam int PW   = cts_pkg::LEVEL_W + cts_pkg::COSH_W;
  localparam int CW   = PW + 1;
  localparam int EXTW = CW - cts_pkg::ENERGY_W - cts_pkg::Q10_SHIFT;

  localparam logic [63:0] Q32_ONE   = 64'd4294967296;
  localparam logic [63:0] Q32_LIMIT = 64'd274877906944;
  localparam logic [63:0] D_REM_Q56 = 64'd699051;

  typedef logic [cts_pkg::COSH_W-1:0] rom_t [COSH_TABLE_ENTRIES];

  // (cosh(1/256) - 1) * c, all in Q32.
  function automatic logic [63:0] cosh_excess(input logic [63:0] c);
    return (c >> 17) + ((c * D_REM_Q56) >> 56);
  endfunction

  function automatic logic [cts_pkg::COSH_W-1:0] to_q10(input logic [63:0] c);
    logic [63:0] v;
    v = (c + (64'd1 << 21)) >> 22;
    return (v > 64'hFFFF) ? {cts_pkg::COSH_W{1'b1}} : v[cts_pkg::COSH_W-1:0];
  endfunction

  // Builds cosh(k/256) by the recurrence c(k+1) = 2c(k) - c(k-1) + 2e(c(k)).
  function automatic rom_t build_cosh();
    rom_t        t;
    logic [63:0] prev;
    logic [63:0] cur;
    logic [63:0] nxt;
    logic        sat;
    prev = Q32_ONE;
    cur  = Q32_ONE;
    sat  = 1'b0;
    for (int k = 0; k < COSH_TABLE_ENTRIES; k++) begin
      if (sat || (cur >= Q32_LIMIT)) begin
        sat  = 1'b1;
        t[k] = {cts_pkg::COSH_W{1'b1}};
      end else begin
        t[k] = to_q10(cur);
        if (k == 0) begin
          cur = Q32_ONE + cosh_excess(Q32_ONE);
        end else begin
          nxt  = 2 * cur - prev + 2 * cosh_excess(cur);
          prev = cur;
          cur  = nxt;
        end
      end
    end
    return t;
  endfunction

  localparam rom_t COSH_ROM = build_cosh();

  // Configuration registers.
  logic                         et_min_enable;
  logic                         et_max_enable;
  logic [cts_pkg::LEVEL_W-1:0]  et_min_level;
  logic [cts_pkg::LEVEL_W-1:0]  et_max_level;
  logic                         kill_event_on_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      et_min_enable      <= 1'b0;
      et_max_enable      <= 1'b0;
      et_min_level       <= '0;
      et_max_level       <= '0;
      kill_event_on_high <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cts_pkg::REG_ET_MIN_ENABLE:      et_min_enable      <= cfg_data[0];
        cts_pkg::REG_ET_MAX_ENABLE:      et_max_enable      <= cfg_data[0];
        cts_pkg::REG_ET_MIN_LEVEL:       et_min_level       <= cfg_data;
        cts_pkg::REG_ET_MAX_LEVEL:       et_max_level       <= cfg_data;
        cts_pkg::REG_KILL_EVENT_ON_HIGH: kill_event_on_high <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Tower address and range check.
  logic [TXW-1:0] tower_ext;
  logic           in_range;
  logic [AW-1:0]  tower_addr;

  assign tower_ext  = TXW'(tower_number);
  assign in_range   = (tower_ext < TXW'(NUM_TOWERS));
  assign tower_addr = tower_ext[AW-1:0];

  // Reset sweep counter.
  logic [AW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Bad map memory: one write port shared by the sweep and mark items.
  logic          bad_map [NUM_TOWERS];
  logic          map_we;
  logic [AW-1:0] map_waddr;
  logic          map_wdata;
  logic          bad_rd;

  assign map_we    = cmd.clear_step || (cmd.mark && in_range);
  assign map_waddr = cmd.clear_step ? clr_cnt : tower_addr;
  assign map_wdata = !cmd.clear_step;

  always_ff @(posedge clk) begin
    if (map_we) bad_map[map_waddr] <= map_wdata;
    if (cmd.capture) bad_rd <= bad_map[tower_addr];
  end

  // Cosh index from |eta|, saturated at the last entry.
  logic [cts_pkg::ETA_W-1:0] eta_mag;
  logic [IXW-1:0]            idx_ext;
  logic [IW-1:0]             cosh_idx;

  assign eta_mag  = pseudorapidity[cts_pkg::ETA_W-1]
                    ? cts_pkg::ETA_W'(-pseudorapidity)
                    : cts_pkg::ETA_W'(pseudorapidity);
  assign idx_ext  = IXW'(eta_mag[cts_pkg::ETA_W-1:cts_pkg::ETA_SHIFT]);
  assign cosh_idx = (idx_ext >= IXW'(COSH_TABLE_ENTRIES))
                    ? IW'(COSH_TABLE_ENTRIES - 1) : idx_ext[IW-1:0];

  // Lookup stage.
  logic [cts_pkg::COSH_W-1:0]       cosh_q;
  logic signed [cts_pkg::ENERGY_W-1:0] energy_q;
  logic                             in_range_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cosh_q     <= COSH_ROM[cosh_idx];
      energy_q   <= tower_energy;
      in_range_q <= in_range;
    end
  end

  // Multiply stage.
  logic [PW-1:0] prod_min;
  logic [PW-1:0] prod_max;
  logic          bad_q;

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      prod_min <= PW'(et_min_level) * PW'(cosh_q);
      prod_max <= PW'(et_max_level) * PW'(cosh_q);
      bad_q    <= in_range_q && bad_rd;
    end
  end

  // Compare stage: energy * 1024 against level * cosh.
  logic signed [CW-1:0]          lhs;
  logic signed [CW-1:0]          rhs_min;
  logic signed [CW-1:0]          rhs_max;
  logic                          min_fail;
  logic                          max_fail;
  logic [cts_pkg::VERDICT_W-1:0] verdict_next;

  assign lhs      = {{EXTW{energy_q[cts_pkg::ENERGY_W-1]}}, energy_q,
                     {cts_pkg::Q10_SHIFT{1'b0}}};
  assign rhs_min  = {1'b0, prod_min};
  assign rhs_max  = {1'b0, prod_max};
  assign min_fail = et_min_enable && !(lhs > rhs_min);
  assign max_fail = et_max_enable && !(lhs < rhs_max);

  always_comb begin
    priority if (bad_q || min_fail) begin
      verdict_next = cts_pkg::VERDICT_REJECT_TOWER;
    end else if (max_fail) begin
      verdict_next = kill_event_on_high ? cts_pkg::VERDICT_REJECT_EVENT
                                        : cts_pkg::VERDICT_REJECT_TOWER;
    end else begin
      verdict_next = cts_pkg::VERDICT_ACCEPT;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) verdict <= verdict_next;
  end

  always_comb begin
    status            = '0;
    status.is_mark    = (command == cts_pkg::CMD_MARK);
    status.clear_last = (clr_cnt == AW'(NUM_TOWERS - 1));
    status.out_free   = !out_valid || out_ready;
  end

endmodule

// ===== design/calorimeter_tower_selector.sv =====
// ----------------------------------------------------------------------------
// calorimeter_tower_selector: tower quality and transverse energy selection
// Items arrive on the in channel (command, tower_number, tower_energy,
// pseudorapidity) and verdicts leave on the out channel; both use valid and
// ready. A mark command sets the tower's bad bit and completes on its
// transfer, so marks can be taken every cycle while the input is open. A
// select command looks up the bad bit and cosh(|eta|) in the transfer
// cycle, forms both threshold products in the next, and then loads the
// verdict into the output register in its compare step; no new item is
// taken until that verdict is loaded. The verdict is visible on out the cycle after it is loaded.
// The output register lets the next item be taken while a verdict waits;
// if the receiver stalls, a select item holds in its compare step until
// the register frees, and in_ready stays low meanwhile.
// Registers are written through the cfg channel, which is always ready.
// After reset the bad map is swept to zero, one tower per cycle; in_ready
// is low during the sweep while configuration transfers are still taken.
// ----------------------------------------------------------------------------
module calorimeter_tower_selector #(
  parameter int NUM_TOWERS         = 8192,
  parameter int COSH_TABLE_ENTRIES = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   command,
  input  logic        [cts_pkg::TOWER_W-1:0]     tower_number,
  input  logic signed [cts_pkg::ENERGY_W-1:0]    tower_energy,
  input  logic signed [cts_pkg::ETA_W-1:0]       pseudorapidity,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic        [cts_pkg::VERDICT_W-1:0]   verdict,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [cts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic        [cts_pkg::CFG_DATA_W-1:0]  cfg_data
);

  cts_pkg::ctrl_cmd_t    cmd;
  cts_pkg::ctrl_status_t status;

  assign cfg_ready = 1'b1;

  cts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cts_datapath #(
    .NUM_TOWERS         (NUM_TOWERS),
    .COSH_TABLE_ENTRIES (COSH_TABLE_ENTRIES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .command        (command),
    .tower_number   (tower_number),
    .tower_energy   (tower_energy),
    .pseudorapidity (pseudorapidity),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .verdict        (verdict),
    .cmd            (cmd),
    .status         (status)
  );

  // A select transfer occupies the block for its multiply and compare steps.
  a_select_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (command == cts_pkg::CMD_SELECT)) |=> !in_ready)
    else $error("in_ready high right after a select transfer");

  // A mark transfer completes at once and leaves the input open.
  a_mark_single: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (command == cts_pkg::CMD_MARK)) |=> in_ready)
    else $error("in_ready dropped after a mark transfer");

  // The bad map sweep keeps the input closed right after reset.
  a_sweep_closed: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("input opened before the bad map sweep");

  // A verdict can only be loaded once a select item has passed through.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && !$past(rst)) |-> !$past(in_ready))
    else $error("verdict appeared without a select item in flight");

endmodule

// ===== dv/cts_verdict_checker.sv =====
// ----------------------------------------------------------------------------
// cts_verdict_checker: verdict prediction and scoreboard
// Watches the configuration, item and verdict channels of the calorimeter
// tower selector. It keeps its own bad tower map, register copies and cosh
// table, predicts the verdict of every select transfer, and compares each
// verdict transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module cts_verdict_checker #(
  parameter int NUM_TOWERS         = 8192,
  parameter int COSH_TABLE_ENTRIES = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic                                   command,
  input  logic        [cts_pkg::TOWER_W-1:0]     tower_number,
  input  logic signed [cts_pkg::ENERGY_W-1:0]    tower_energy,
  input  logic signed [cts_pkg::ETA_W-1:0]       pseudorapidity,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic        [cts_pkg::VERDICT_W-1:0]   verdict,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic        [cts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic        [cts_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                     mismatch_count,
  output int                                     verdicts_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit [63:0] ONE_Q32   = 64'h1_0000_0000;
  localparam bit [63:0] LIMIT_Q32 = 64'h40_0000_0000;

  bit [cts_pkg::COSH_W-1:0]      cosh_q10 [COSH_TABLE_ENTRIES];
  bit                            bad_tower [NUM_TOWERS];
  bit                            cut_min_on;
  bit                            cut_max_on;
  bit                            kill_event;
  logic [cts_pkg::LEVEL_W-1:0]   min_level;
  logic [cts_pkg::LEVEL_W-1:0]   max_level;
  logic [cts_pkg::VERDICT_W-1:0] verdict_q [$];

  // cosh(x + 1/256) - cosh(x) grows by (cosh(1/256) - 1) * cosh(x) per step;
  // the factor is split into 2^-17 plus a Q56 remainder.
  function automatic bit [63:0] cosh_step_excess(bit [63:0] c);
    return (c >> 17) + ((c * 64'd699051) >> 56);
  endfunction

  initial begin : build_cosh
    bit [63:0] prev;
    bit [63:0] cur;
    bit [63:0] nxt;
    bit [63:0] rounded;
    bit        saturated;
    prev = ONE_Q32;
    cur = ONE_Q32;
    saturated = 1'b0;
    for (int k = 0; k < COSH_TABLE_ENTRIES; k++) begin
      if (saturated || cur >= LIMIT_Q32) begin
        saturated = 1'b1;
        cosh_q10[k] = '1;
      end else begin
        rounded = (cur + (64'd1 << 21)) >> 22;
        cosh_q10[k] = (rounded > 64'hFFFF) ? 16'hFFFF : rounded[15:0];
        if (k == 0) begin
          cur = ONE_Q32 + cosh_step_excess(ONE_Q32);
        end else begin
          nxt = 2 * cur - prev + 2 * cosh_step_excess(cur);
          prev = cur;
          cur = nxt;
        end
      end
    end
  end

  function automatic logic [cts_pkg::VERDICT_W-1:0] tower_verdict(
    input logic        [cts_pkg::TOWER_W-1:0]  tower,
    input logic signed [cts_pkg::ENERGY_W-1:0] energy,
    input logic signed [cts_pkg::ETA_W-1:0]    eta
  );
    longint magnitude;
    longint slot;
    longint cosh_val;
    longint scaled;
    bit     marked;
    magnitude = longint'(eta);
    if (magnitude < 0) magnitude = -magnitude;
    slot = magnitude >> cts_pkg::ETA_SHIFT;
    if (slot >= COSH_TABLE_ENTRIES) slot = COSH_TABLE_ENTRIES - 1;
    cosh_val = longint'(cosh_q10[slot]);
    scaled = longint'(energy) << cts_pkg::Q10_SHIFT;
    marked = (tower < NUM_TOWERS) && bad_tower[tower];
    if (marked || (cut_min_on && !(scaled > longint'(min_level) * cosh_val)))
      return cts_pkg::VERDICT_REJECT_TOWER;
    if (cut_max_on && !(scaled < longint'(max_level) * cosh_val))
      return kill_event ? cts_pkg::VERDICT_REJECT_EVENT
                        : cts_pkg::VERDICT_REJECT_TOWER;
    return cts_pkg::VERDICT_ACCEPT;
  endfunction

  always @(posedge clk) begin : track
    logic [cts_pkg::VERDICT_W-1:0] want;
    if (rst) begin
      for (int t = 0; t < NUM_TOWERS; t++) bad_tower[t] = 1'b0;
      cut_min_on = 1'b0;
      cut_max_on = 1'b0;
      min_level = '0;
      max_level = '0;
      kill_event = 1'b1;
      mismatch_count = 0;
      verdict_q.delete();
    end else begin
      // A verdict leaving now belongs to an earlier item, so retire it first.
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          mismatch_count++;
          $error("verdict: no verdict expected, actual %0d", verdict);
        end else begin
          want = verdict_q.pop_front();
          if (verdict !== want) begin
            mismatch_count++;
            $error("verdict: expected %0d, actual %0d", want, verdict);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cts_pkg::REG_ET_MIN_ENABLE:      cut_min_on = cfg_data[0];
          cts_pkg::REG_ET_MAX_ENABLE:      cut_max_on = cfg_data[0];
          cts_pkg::REG_ET_MIN_LEVEL:       min_level = cfg_data[cts_pkg::LEVEL_W-1:0];
          cts_pkg::REG_ET_MAX_LEVEL:       max_level = cfg_data[cts_pkg::LEVEL_W-1:0];
          cts_pkg::REG_KILL_EVENT_ON_HIGH: kill_event = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (command == cts_pkg::CMD_MARK) begin
          if (tower_number < NUM_TOWERS) bad_tower[tower_number] = 1'b1;
        end else begin
          verdict_q.push_back(tower_verdict(tower_number, tower_energy,
                                            pseudorapidity));
        end
      end
    end
    verdicts_due = verdict_q.size();
  end

endmodule

// ===== dv/calorimeter_tower_selector_tb.sv =====
// ----------------------------------------------------------------------------
// calorimeter_tower_selector_tb: stimulus and verdict for the tower selector
// Runs a directed set of extremes and corner cases, then phases of random
// mark and select items under changing cut settings, with random idling on
// both channels, a long receiver hold-off, and a quiet final phase. The
// checker beside the block predicts and compares every verdict.
// ----------------------------------------------------------------------------
module calorimeter_tower_selector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES      = 10;
  localparam int PHASE_ITEMS     = 92;
  localparam int HOLD_OFF_PHASE  = 3;
  localparam int HOLD_OFF_CYCLES = 300;
  // The bad map sweep after reset keeps the item channel closed; that is
  // the longest quiet stretch of a correct run.
  localparam int WATCHDOG_LIMIT  = 40000;
  localparam logic [cts_pkg::LEVEL_W-1:0] LEVEL_TOP = '1;

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               in_valid;
  logic                               in_ready;
  logic                               command;
  logic        [cts_pkg::TOWER_W-1:0]     tower_number;
  logic signed [cts_pkg::ENERGY_W-1:0]    tower_energy;
  logic signed [cts_pkg::ETA_W-1:0]       pseudorapidity;
  logic                               out_valid;
  logic                               out_ready;
  logic        [cts_pkg::VERDICT_W-1:0]   verdict;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic        [cts_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic        [cts_pkg::CFG_DATA_W-1:0]  cfg_data;

  int mismatch_count;
  int verdicts_due;
  int idle_cycles;
  bit tx_gaps;
  bit rx_stalls;
  bit hold_off_req;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  calorimeter_tower_selector uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .tower_number  (tower_number),
    .tower_energy  (tower_energy),
    .pseudorapidity(pseudorapidity),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .verdict       (verdict),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  cts_verdict_checker verdict_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .tower_number  (tower_number),
    .tower_energy  (tower_energy),
    .pseudorapidity(pseudorapidity),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .verdict       (verdict),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .verdicts_due  (verdicts_due)
  );

  // Ends the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall bursts, or one long hold-off on request.
  initial begin : receiver
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic write_reg(input logic [cts_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [cts_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Enable bits carry random upper bits, which the block must mask off.
  task automatic apply_settings(input bit min_on, input bit max_on,
                                input logic [cts_pkg::LEVEL_W-1:0] min_lvl,
                                input logic [cts_pkg::LEVEL_W-1:0] max_lvl,
                                input bit kill);
    logic [31:0] noise;
    logic [31:0] junk;
    noise = $urandom;
    write_reg(cts_pkg::REG_ET_MIN_ENABLE,
              {noise[cts_pkg::CFG_DATA_W-1:1], min_on});
    noise = $urandom;
    write_reg(cts_pkg::REG_ET_MAX_ENABLE,
              {noise[cts_pkg::CFG_DATA_W-1:1], max_on});
    write_reg(cts_pkg::REG_ET_MIN_LEVEL, min_lvl);
    write_reg(cts_pkg::REG_ET_MAX_LEVEL, max_lvl);
    noise = $urandom;
    write_reg(cts_pkg::REG_KILL_EVENT_ON_HIGH,
              {noise[cts_pkg::CFG_DATA_W-1:1], kill});
    // An index past the register list must leave every register alone.
    noise = $urandom_range(cts_pkg::REG_KILL_EVENT_ON_HIGH + 1,
                           (1 << cts_pkg::CFG_INDEX_W) - 1);
    junk = $urandom;
    write_reg(noise[cts_pkg::CFG_INDEX_W-1:0], junk[cts_pkg::CFG_DATA_W-1:0]);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_item(input logic cmd,
                           input logic [cts_pkg::TOWER_W-1:0] tw,
                           input logic signed [cts_pkg::ENERGY_W-1:0] en,
                           input logic signed [cts_pkg::ETA_W-1:0] et,
                           input bit allow_gap);
    if (allow_gap && tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    tower_number <= tw;
    tower_energy <= en;
    pseudorapidity <= et;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (verdicts_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic                               cmd;
    logic        [cts_pkg::TOWER_W-1:0]  tw;
    logic signed [cts_pkg::ENERGY_W-1:0] en;
    logic signed [cts_pkg::ETA_W-1:0]    et;
    logic [31:0]                        rnd;
    logic [31:0]                        lvl_a;
    logic [31:0]                        lvl_b;
    rst = 1'b1;
    in_valid = 1'b0;
    command = cts_pkg::CMD_SELECT;
    tower_number = '0;
    tower_energy = '0;
    pseudorapidity = '0;
    cfg_valid = 1'b0;
    cfg_index = cts_pkg::REG_ET_MIN_ENABLE;
    cfg_data = '0;
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    hold_off_req = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Both cuts on, whole-event rejection on the upper cut.
    apply_settings(1'b1, 1'b1, 15'd100, 15'd2000, 1'b1);
    push_item(cts_pkg::CMD_SELECT, 13'd0, 16'sd0, 15'sd0, 1'b1);
    push_item(cts_pkg::CMD_SELECT, 13'd1, 16'h8000, 15'sd0, 1'b1);
    push_item(cts_pkg::CMD_SELECT, 13'd2, 16'h7FFF, 15'sd0, 1'b1);
    push_item(cts_pkg::CMD_SELECT, 13'd3, 16'sd500, 15'sd0, 1'b1);
    push_item(cts_pkg::CMD_SELECT, 13'd3, 16'sd500, 15'h4000, 1'b1);
    push_item(cts_pkg::CMD_SELECT, 13'd3, 16'h7FFF, 15'h3FFF, 1'b1);
    push_item(cts_pkg::CMD_SELECT, 13'd5, 16'sd1000, 15'h1000, 1'b1);
    push_item(cts_pkg::CMD_SELECT, 13'd5, 16'sd1000, 15'h7000, 1'b1);
    push_item(cts_pkg::CMD_SELECT, 13'd6, 16'sd101, 15'sd15, 1'b1);
    push_item(cts_pkg::CMD_SELECT, 13'd6, 16'sd101, 15'h7FF0, 1'b1);
    push_item(cts_pkg::CMD_SELECT, 13'd4, 16'sd2000, 15'sd0, 1'b1);
    push_item(cts_pkg::CMD_SELECT, 13'd4, 16'sd100, 15'sd0, 1'b1);
    push_item(cts_pkg::CMD_MARK, 13'h1FFF, 16'h8000, 15'h7FFF, 1'b1);
    push_item(cts_pkg::CMD_SELECT, 13'h1FFF, 16'sd500, 15'sd0, 1'b1);
    push_item(cts_pkg::CMD_MARK, 13'd0, 16'h7FFF, 15'h4000, 1'b1);
    push_item(cts_pkg::CMD_MARK, 13'd0, 16'sd0, 15'sd0, 1'b1);
    push_item(cts_pkg::CMD_SELECT, 13'd0, 16'sd500, 15'sd0, 1'b1);
    in_valid <= 1'b0;
    wait_drained();

    // Zero upper level with tower-only rejection; then both cuts off.
    apply_settings(1'b0, 1'b1, 15'd0, 15'd0, 1'b0);
    push_item(cts_pkg::CMD_SELECT, 13'd9, -16'sd5, 15'sd0, 1'b1);
    push_item(cts_pkg::CMD_SELECT, 13'd9, 16'sd0, 15'sd0, 1'b1);
    push_item(cts_pkg::CMD_SELECT, 13'd9, 16'sd7, 15'h3FFF, 1'b1);
    in_valid <= 1'b0;
    wait_drained();
    apply_settings(1'b0, 1'b0, LEVEL_TOP, LEVEL_TOP, 1'b1);
    push_item(cts_pkg::CMD_SELECT, 13'd10, 16'h8000, 15'h4000, 1'b1);
    push_item(cts_pkg::CMD_SELECT, 13'h1FFF, 16'h7FFF, 15'sd0, 1'b1);
    in_valid <= 1'b0;
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) begin
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
      end
      rnd = $urandom;
      lvl_a = $urandom_range(0, 3000);
      lvl_b = $urandom_range(0, 32767);
      case (p)
        0: apply_settings(1'b1, 1'b1, '0, '0, rnd[0]);
        1: apply_settings(1'b1, 1'b1, LEVEL_TOP, LEVEL_TOP, 1'b1);
        2: apply_settings(1'b1, 1'b1, '0, LEVEL_TOP, 1'b0);
        default: apply_settings(rnd[0], rnd[1],
                                lvl_a[cts_pkg::LEVEL_W-1:0],
                                lvl_b[cts_pkg::LEVEL_W-1:0], rnd[2]);
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // The receiver goes quiet while the sender keeps offering items.
        if (p == HOLD_OFF_PHASE && i == 0) hold_off_req = 1'b1;
        cmd = ($urandom_range(0, 6) == 0) ? cts_pkg::CMD_MARK : cts_pkg::CMD_SELECT;
        if ($urandom_range(0, 1) != 0) rnd = $urandom_range(0, 255);
        else rnd = $urandom;
        tw = rnd[cts_pkg::TOWER_W-1:0];
        if ($urandom_range(0, 1) != 0) rnd = $urandom;
        else rnd = $urandom_range(0, 8000);
        en = rnd[cts_pkg::ENERGY_W-1:0];
        rnd = $urandom;
        et = rnd[cts_pkg::ETA_W-1:0];
        push_item(cmd, tw, en, et, !(p == HOLD_OFF_PHASE && i < 40));
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== calorimeter_tower_selector.f =====
design/cts_pkg.sv
design/cts_ctrl.sv
design/cts_datapath.sv
design/calorimeter_tower_selector.sv
dv/cts_verdict_checker.sv
dv/calorimeter_tower_selector_tb.sv
